// ===== src/impedance_motor_can_frame_codec_unit_assert.svh =====
// Assertion macros shared by the codec RTL.
// Each macro expects signals named clk and rst in the calling scope.
`ifndef IMPEDANCE_MOTOR_CAN_FRAME_CODEC_UNIT_ASSERT_SVH
`define IMPEDANCE_MOTOR_CAN_FRAME_CODEC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IMCFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imcfc: same-cycle check failed");
`define IMCFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imcfc: next-cycle check failed");
`else
`define IMCFC_ASSERT_IMPL(label, ante, cons)
`define IMCFC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/imcfc_pkg.sv =====
`default_nettype none
package imcfc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [15:0] CODE16_MAX = 16'hFFFF;
  localparam logic [11:0] CODE12_MAX = 12'hFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSITION_LIMIT,
    REG_VELOCITY_LIMIT,
    REG_CURRENT_LIMIT,
    REG_STIFFNESS_LIMIT,
    REG_DAMPING_LIMIT,
    REG_TORQUE_CONSTANT,
    REG_MOTOR_ADDRESS,
    REG_FLIP_SENSE
  } cfg_reg_t;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] torque_request;
    logic signed [31:0] position_target;
    logic signed [31:0] velocity_target;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
    logic               motor_enabled;
    logic [47:0]        reply_bytes;
  } request_t;

  typedef struct packed {
    logic [63:0]        command_frame;
    logic               frame_send;
    logic signed [31:0] current_command;
    logic               reply_match;
    logic signed [31:0] measured_position;
    logic signed [31:0] measured_velocity;
    logic signed [31:0] measured_current;
  } response_t;

  typedef struct packed {
    logic               cmd;
    logic               enabled;
    logic               torque_neg;
    logic               match;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic [30:0]        kp;
    logic [30:0]        kd;
    logic [39:0]        codes;
  } front_t;

  typedef struct packed {
    logic               cmd;
    logic               enabled;
    logic               match;
    logic signed [31:0] cur;
  } back_t;

endpackage
`default_nettype wire

// ===== src/imcfc_if.sv =====
`default_nettype none
interface imcfc_request_if import imcfc_pkg::*; ();
  logic     valid;
  logic     ready;
  request_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface imcfc_response_if import imcfc_pkg::*; ();
  logic      valid;
  logic      ready;
  response_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/imcfc_div.sv =====
`default_nettype none
`include "impedance_motor_can_frame_codec_unit_assert.svh"
module imcfc_div #(
  parameter int DW    = 48,
  parameter int VW    = 32,
  parameter int LANES = 1,
  parameter int SW    = 1,
  parameter int BPS   = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [LANES-1:0][DW-1:0]      dividend,
  input  wire logic [LANES-1:0][VW-1:0]      divisor,
  input  wire logic [SW-1:0]                 side_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [LANES-1:0][DW-1:0]           quotient,
  output logic [SW-1:0]                      side_out
);

  localparam int NS = (DW + BPS - 1) / BPS;
  localparam int AW = NS * BPS;

  logic                        v    [NS];
  logic [NS-1:0]               en;
  logic [LANES-1:0][AW-1:0]    acc  [NS];
  logic [LANES-1:0][VW-1:0]    rem  [NS];
  logic [LANES-1:0][VW-1:0]    div  [NS];
  logic [SW-1:0]               side [NS];

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [LANES-1:0][AW-1:0] a_src;
    logic [LANES-1:0][AW-1:0] a_nxt;
    logic [LANES-1:0][VW-1:0] r_src;
    logic [LANES-1:0][VW-1:0] r_nxt;
    logic [LANES-1:0][VW-1:0] d_src;
    logic [SW-1:0]            s_src;
    logic                     v_src;

    if (k == 0) begin : g_head
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          a_src[l] = AW'(dividend[l]);
          r_src[l] = '0;
          d_src[l] = divisor[l];
        end
        s_src = side_in;
        v_src = in_valid;
      end
    end else begin : g_body
      assign a_src = acc[k-1];
      assign r_src = rem[k-1];
      assign d_src = div[k-1];
      assign s_src = side[k-1];
      assign v_src = v[k-1];
    end

    always_comb begin : step
      logic [VW:0]   t;
      logic [AW-1:0] a;
      logic [VW-1:0] r;
      for (int l = 0; l < LANES; l++) begin
        a = a_src[l];
        r = r_src[l];
        for (int j = 0; j < BPS; j++) begin
          t = {r, a[AW-1]};
          a = {a[AW-2:0], 1'b0};
          if (t >= {1'b0, d_src[l]}) begin
            t = t - {1'b0, d_src[l]};
            a[0] = 1'b1;
          end
          r = t[VW-1:0];
        end
        a_nxt[l] = a;
        r_nxt[l] = r;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        acc[k]  <= a_nxt;
        rem[k]  <= r_nxt;
        div[k]  <= d_src;
        side[k] <= s_src;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quotient[l] = acc[NS-1][l][DW-1:0];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];
  assign side_out  = side[NS-1];

  `IMCFC_ASSERT_IMPL(a_rem_below_divisor, v[NS-1], rem[NS-1][0] < div[NS-1][0])
  `IMCFC_ASSERT_IMPL(a_divisor_nonzero, v[NS-1], div[NS-1][0] != '0)
  `IMCFC_ASSERT_NEXT(a_head_loads, in_valid && in_ready, v[0])

endmodule
`default_nettype wire

// ===== src/impedance_motor_can_frame_codec_unit.sv =====
// An accepted request passes the input register, 12-stage current divider, scaling
// register, 12-stage code divider and output register. Each divider stage resolves
// DIV_BITS quotient bits. Throughput: one request per cycle unless the output stalls.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
`default_nettype none
`include "impedance_motor_can_frame_codec_unit_assert.svh"
module impedance_motor_can_frame_codec_unit import imcfc_pkg::*; #(
  parameter int DIV_BITS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  imcfc_request_if.sink              request,
  imcfc_response_if.source           response
);

  localparam int LANE_P  = 0;
  localparam int LANE_V  = 1;
  localparam int LANE_KP = 2;
  localparam int LANE_KD = 3;
  localparam int LANE_I  = 4;
  localparam int LANES   = 5;

  logic [30:0] position_limit;
  logic [30:0] velocity_limit;
  logic [30:0] current_limit;
  logic [30:0] stiffness_limit;
  logic [30:0] damping_limit;
  logic [30:0] torque_constant;
  logic [7:0]  motor_address;
  logic        flip_sense;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit  <= 31'd819200;
      velocity_limit  <= 31'd2743992;
      current_limit   <= 31'd1441792;
      stiffness_limit <= 31'd32768000;
      damping_limit   <= 31'd327680;
      torque_constant <= 31'd26739;
      motor_address   <= 8'd1;
      flip_sense      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POSITION_LIMIT:  position_limit  <= cfg_data;
        REG_VELOCITY_LIMIT:  velocity_limit  <= cfg_data;
        REG_CURRENT_LIMIT:   current_limit   <= cfg_data;
        REG_STIFFNESS_LIMIT: stiffness_limit <= cfg_data;
        REG_DAMPING_LIMIT:   damping_limit   <= cfg_data;
        REG_TORQUE_CONSTANT: torque_constant <= cfg_data;
        REG_MOTOR_ADDRESS:   motor_address   <= cfg_data[7:0];
        REG_FLIP_SENSE:      flip_sense      <= cfg_data[0];
      endcase
    end
  end

  logic     s0_v;
  request_t s0;
  logic     ready0;
  logic     f_in_ready;

  assign ready0        = !s0_v || f_in_ready;
  assign request.ready = ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (ready0) begin
      s0_v <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0) begin
      s0 <= request.data;
    end
  end

  logic signed [33:0] p_raw;
  logic signed [33:0] v_raw;
  logic signed [33:0] plim_s;
  logic signed [33:0] plim_n;
  logic signed [33:0] vlim_s;
  logic signed [33:0] vlim_n;
  logic signed [32:0] kp_raw;
  logic signed [32:0] kd_raw;
  logic signed [32:0] kplim_s;
  logic signed [32:0] kdlim_s;
  logic [31:0]        tmag;
  front_t             f_in;
  logic [0:0][47:0]   f_dividend;
  logic [0:0][30:0]   f_divisor;

  always_comb begin
    p_raw   = 34'(s0.position_target);
    v_raw   = 34'(s0.velocity_target);
    if (flip_sense) begin
      p_raw = -p_raw;
      v_raw = -v_raw;
    end
    plim_s  = {3'b000, position_limit};
    plim_n  = -plim_s;
    vlim_s  = {3'b000, velocity_limit};
    vlim_n  = -vlim_s;
    kp_raw  = 33'(s0.stiffness_gain);
    kd_raw  = 33'(s0.damping_gain);
    kplim_s = {2'b00, stiffness_limit};
    kdlim_s = {2'b00, damping_limit};

    f_in.cmd        = s0.cmd;
    f_in.enabled    = s0.motor_enabled;
    f_in.torque_neg = s0.torque_request[31];
    f_in.match      = s0.reply_bytes[47:40] == motor_address;
    f_in.codes      = s0.reply_bytes[39:0];

    if (p_raw > plim_s) begin
      f_in.pos = plim_s[31:0];
    end else if (p_raw < plim_n) begin
      f_in.pos = plim_n[31:0];
    end else begin
      f_in.pos = p_raw[31:0];
    end

    if (v_raw > vlim_s) begin
      f_in.vel = vlim_s[31:0];
    end else if (v_raw < vlim_n) begin
      f_in.vel = vlim_n[31:0];
    end else begin
      f_in.vel = v_raw[31:0];
    end

    if (kp_raw < 0) begin
      f_in.kp = '0;
    end else if (kp_raw > kplim_s) begin
      f_in.kp = stiffness_limit;
    end else begin
      f_in.kp = kp_raw[30:0];
    end

    if (kd_raw < 0) begin
      f_in.kd = '0;
    end else if (kd_raw > kdlim_s) begin
      f_in.kd = damping_limit;
    end else begin
      f_in.kd = kd_raw[30:0];
    end

    tmag          = s0.torque_request[31] ? (~s0.torque_request + 32'd1) : s0.torque_request;
    f_dividend[0] = {tmag, 16'h0000};
    f_divisor[0]  = (torque_constant == '0) ? 31'd1 : torque_constant;
  end

  logic             f_out_valid;
  logic             f_out_ready;
  logic [0:0][47:0] f_q;
  front_t           f_side;

  imcfc_div #(
    .DW    (48),
    .VW    (31),
    .LANES (1),
    .SW    ($bits(front_t)),
    .BPS   (DIV_BITS)
  ) u_cur_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_v),
    .in_ready  (f_in_ready),
    .dividend  (f_dividend),
    .divisor   (f_divisor),
    .side_in   (f_in),
    .out_valid (f_out_valid),
    .out_ready (f_out_ready),
    .quotient  (f_q),
    .side_out  (f_side)
  );

  logic                   s2_v;
  back_t                  s2_side;
  logic [LANES-1:0][47:0] s2_num;
  logic [LANES-1:0][31:0] s2_den;
  logic                   b_in_ready;

  back_t                  s2_side_next;
  logic [LANES-1:0][47:0] s2_num_next;
  logic [LANES-1:0][31:0] s2_den_next;
  logic [30:0]            cur_mag;
  logic                   cur_neg;
  logic [32:0]            p_sum;
  logic [32:0]            v_sum;
  logic [31:0]            i_ofs;

  assign f_out_ready = !s2_v || b_in_ready;

  always_comb begin
    cur_mag = (f_q[0] > {17'd0, current_limit}) ? current_limit : f_q[0][30:0];
    cur_neg = f_side.torque_neg ^ flip_sense;
    i_ofs   = cur_neg ? ({1'b0, current_limit} - {1'b0, cur_mag})
                      : ({1'b0, current_limit} + {1'b0, cur_mag});
    p_sum   = {f_side.pos[31], f_side.pos} + {2'b00, position_limit};
    v_sum   = {f_side.vel[31], f_side.vel} + {2'b00, velocity_limit};

    s2_side_next.cmd     = f_side.cmd;
    s2_side_next.enabled = f_side.enabled;
    s2_side_next.match   = f_side.match;
    s2_side_next.cur     = cur_neg ? (32'd0 - {1'b0, cur_mag}) : {1'b0, cur_mag};

    if (f_side.cmd == CMD_DECODE) begin
      s2_num_next[LANE_P]  = 48'(f_side.codes[39:24]) * 48'({position_limit, 1'b0});
      s2_den_next[LANE_P]  = 32'(CODE16_MAX);
      s2_num_next[LANE_V]  = 48'(44'(f_side.codes[23:12]) * 44'({velocity_limit, 1'b0}));
      s2_den_next[LANE_V]  = 32'(CODE12_MAX);
      s2_num_next[LANE_I]  = 48'(44'(f_side.codes[11:0]) * 44'({current_limit, 1'b0}));
      s2_den_next[LANE_I]  = 32'(CODE12_MAX);
      s2_num_next[LANE_KP] = '0;
      s2_den_next[LANE_KP] = 32'd1;
      s2_num_next[LANE_KD] = '0;
      s2_den_next[LANE_KD] = 32'd1;
    end else begin
      s2_num_next[LANE_P]  = 48'(p_sum[31:0]);
      s2_den_next[LANE_P]  = {position_limit, 1'b0};
      s2_num_next[LANE_V]  = 48'(v_sum[31:0]);
      s2_den_next[LANE_V]  = {velocity_limit, 1'b0};
      s2_num_next[LANE_I]  = 48'(i_ofs);
      s2_den_next[LANE_I]  = {current_limit, 1'b0};
      s2_num_next[LANE_KP] = 48'(f_side.kp);
      s2_den_next[LANE_KP] = {1'b0, stiffness_limit};
      s2_num_next[LANE_KD] = 48'(f_side.kd);
      s2_den_next[LANE_KD] = {1'b0, damping_limit};
      for (int l = 0; l < LANES; l++) begin
        if (s2_den_next[l] == '0) begin
          s2_num_next[l] = '0;
          s2_den_next[l] = 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (f_out_ready) begin
      s2_v <= f_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_out_ready) begin
      s2_side <= s2_side_next;
      s2_num  <= s2_num_next;
      s2_den  <= s2_den_next;
    end
  end

  logic [LANES-1:0][47:0] b_dividend;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (s2_side.cmd == CMD_DECODE) begin
        b_dividend[l] = s2_num[l];
      end else if (l == LANE_P) begin
        b_dividend[l] = {s2_num[l][31:0], 16'h0000} - s2_num[l];
      end else begin
        b_dividend[l] = {s2_num[l][35:0], 12'h000} - s2_num[l];
      end
    end
  end

  logic                   b_out_valid;
  logic                   b_out_ready;
  logic [LANES-1:0][47:0] b_q;
  back_t                  b_side;

  imcfc_div #(
    .DW    (48),
    .VW    (32),
    .LANES (LANES),
    .SW    ($bits(back_t)),
    .BPS   (DIV_BITS)
  ) u_code_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_v),
    .in_ready  (b_in_ready),
    .dividend  (b_dividend),
    .divisor   (s2_den),
    .side_in   (s2_side),
    .out_valid (b_out_valid),
    .out_ready (b_out_ready),
    .quotient  (b_q),
    .side_out  (b_side)
  );

  logic      o_v;
  response_t o_data;
  response_t o_data_next;
  logic [31:0] meas_p;
  logic [31:0] meas_v;
  logic [31:0] meas_i;

  assign b_out_ready = !o_v || response.ready;

  always_comb begin
    meas_p = flip_sense ? ({1'b0, position_limit} - b_q[LANE_P][31:0])
                        : (b_q[LANE_P][31:0] - {1'b0, position_limit});
    meas_v = flip_sense ? ({1'b0, velocity_limit} - b_q[LANE_V][31:0])
                        : (b_q[LANE_V][31:0] - {1'b0, velocity_limit});
    meas_i = flip_sense ? ({1'b0, current_limit} - b_q[LANE_I][31:0])
                        : (b_q[LANE_I][31:0] - {1'b0, current_limit});
    o_data_next = '0;
    if (b_side.cmd == CMD_DECODE) begin
      o_data_next.reply_match = b_side.match;
      if (b_side.match) begin
        o_data_next.measured_position = meas_p;
        o_data_next.measured_velocity = meas_v;
        o_data_next.measured_current  = meas_i;
      end
    end else begin
      o_data_next.command_frame   = {b_q[LANE_P][15:0], b_q[LANE_V][11:0],
                                     b_q[LANE_KP][11:0], b_q[LANE_KD][11:0],
                                     b_q[LANE_I][11:0]};
      o_data_next.frame_send      = b_side.enabled;
      o_data_next.current_command = b_side.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (b_out_ready) begin
      o_v <= b_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_out_ready) begin
      o_data <= o_data_next;
    end
  end

  assign response.valid = o_v;
  assign response.data  = o_data;

  logic signed [32:0] ilim_s;
  assign ilim_s = {2'b00, current_limit};

  `IMCFC_ASSERT_IMPL(a_send_xor_match, response.valid,
                     !(response.data.frame_send && response.data.reply_match))
  `IMCFC_ASSERT_IMPL(a_current_in_range, response.valid,
                     (response.data.current_command <= ilim_s) &&
                     (response.data.current_command >= -ilim_s))
  `IMCFC_ASSERT_NEXT(a_input_loads, request.valid && request.ready, s0_v)

endmodule
`default_nettype wire
